### hdl/ibl_pkg.sv
// ----------------------------------------------------------------------------
// ibl_pkg
// Shared types, codes and sizing helpers for the indexed byte list.
// ----------------------------------------------------------------------------
package ibl_pkg;

   localparam int unsigned DEFAULT_CAPACITY = 64;
   localparam int unsigned INDEX_W          = 6;
   localparam int unsigned BYTE_W           = 8;
   localparam int unsigned COUNT_FIELD_W    = 7;
   // fan-in of one read tree node, and its log2
   localparam int unsigned TREE_FAN         = 8;
   localparam int unsigned TREE_FAN_BITS    = 3;

   typedef enum logic [1:0] {
      KIND_APPEND = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_READ   = 2'd2,
      KIND_WRITE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_EMPTY  = 2'd1,
      STATUS_BEYOND = 2'd2,
      STATUS_FULL   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_RESP
   } state_type;

   typedef struct packed {
      kind_type                kind;
      logic [INDEX_W-1:0]      index;
      logic [BYTE_W-1:0]       value;
   } req_type;

   typedef struct packed {
      status_type              status;
      logic [BYTE_W-1:0]       read_value;
      logic [COUNT_FIELD_W-1:0] element_count;
      logic                    index_valid;
   } rsp_type;

   // broadcast to every cell in the update cycle
   typedef struct packed {
      logic                    go;
      logic                    ok;
      kind_type                kind;
      logic [BYTE_W-1:0]       value;
   } cmd_type;

   // number of registered levels of the read tree for n leaves
   function automatic int unsigned tree_levels(input int unsigned n);
      int unsigned levels;
      int unsigned span;
      levels = 1;
      span   = TREE_FAN;
      for (int k = 0; k < 16; k++) begin
         if (span < n) begin
            levels = levels + 1;
            span   = span * TREE_FAN;
         end
      end
      return levels;
   endfunction

endpackage

### hdl/indexed_byte_list.sv
// response: after acceptance a request passes the leaf register and every
//   registered level of the read tree of 8-input OR stages, then the response is held
// until taken; a new request is accepted only when idle, after the last response is taken
// list updates (append, remove shift, write) take effect at the accepting edge
// reset: synchronous, active high; clears the element count and the control state,
//   cell contents stay undefined until written
// ----------------------------------------------------------------------------
// indexed_byte_list
// Ordered byte list with append, remove at index, read and write at index,
// built as a row of byte cells with a registered read tree.
// ----------------------------------------------------------------------------
module indexed_byte_list #(
   parameter int unsigned CAPACITY = ibl_pkg::DEFAULT_CAPACITY
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ibl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ibl_pkg::rsp_type rsp_data
);
   import ibl_pkg::*;

   localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
   localparam int unsigned CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
   localparam int unsigned LEVELS = tree_levels(CAPACITY);
   localparam int unsigned WAIT_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [WAIT_W-1:0]  wait_ff, wait_in;
   status_type         status_ff, status_in;
   logic               valid_ff;
   logic               rd_en_ff;

   logic               req_accept;
   logic [CMP_W-1:0]   idx_ext;
   logic [CMP_W-1:0]   cnt_ext;
   logic               idx_ok;
   logic               full;
   logic               empty;
   logic               op_ok;
   cmd_type            cmd;
   logic [BYTE_W-1:0]  root;

   logic [CAPACITY-1:0][BYTE_W-1:0] cell_data;
   logic [CAPACITY-1:0][BYTE_W-1:0] cell_tap;

   assign req_accept = req_valid && !req_stall;
   assign idx_ext    = CMP_W'(req_data.index);
   assign cnt_ext    = CMP_W'(count_ff);
   assign idx_ok     = idx_ext < cnt_ext;
   assign full       = count_ff == CNT_W'(CAPACITY);
   assign empty      = count_ff == '0;

   always_comb begin
      status_in = STATUS_OK;
      count_in  = count_ff;
      op_ok     = 1'b0;
      case (req_data.kind)
         KIND_APPEND: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               op_ok    = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         KIND_REMOVE: begin
            // empty is reported ahead of a bad index
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else if (!idx_ok) begin
               status_in = STATUS_BEYOND;
            end else begin
               op_ok    = 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         KIND_READ, KIND_WRITE: begin
            if (!idx_ok) begin
               status_in = STATUS_BEYOND;
            end else begin
               op_ok = 1'b1;
            end
         end
         default: begin
            status_in = STATUS_OK;
         end
      endcase
   end

   assign cmd.go    = req_accept;
   assign cmd.ok    = op_ok;
   assign cmd.kind  = req_data.kind;
   assign cmd.value = req_data.value;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [BYTE_W-1:0] neighbor;
      if (i == CAPACITY - 1) begin : g_last
         assign neighbor = '0;
      end else begin : g_mid
         assign neighbor = cell_data[i+1];
      end

      ibl_cell #(
         .POS   (i),
         .CMP_W (CMP_W)
      ) u_cell (
         .clock    (clock),
         .cmd      (cmd),
         .index    (idx_ext),
         .count    (cnt_ext),
         .neighbor (neighbor),
         .data     (cell_data[i]),
         .tap      (cell_tap[i])
      );
   end

   ibl_or_tree #(
      .LEAVES (CAPACITY)
   ) u_tree (
      .clock (clock),
      .load  (req_accept),
      .taps  (cell_tap),
      .root  (root)
   );

   always_comb begin
      state_in  = state_ff;
      wait_in   = wait_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = ST_REDUCE;
               wait_in  = WAIT_W'(LEVELS - 1);
            end
         end
         ST_REDUCE: begin
            if (wait_ff == '0) begin
               state_in = ST_RESP;
            end else begin
               wait_in = wait_ff - 1'b1;
            end
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (req_accept) count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      wait_ff <= wait_in;
      if (req_accept) begin
         status_ff <= status_in;
         valid_ff  <= idx_ok;
         rd_en_ff  <= (req_data.kind == KIND_READ) && idx_ok;
      end
   end

   assign rsp_data.status        = status_ff;
   assign rsp_data.read_value    = rd_en_ff ? root : '0;
   assign rsp_data.element_count = COUNT_FIELD_W'(count_ff);
   assign rsp_data.index_valid   = valid_ff;

`ifndef ASSERT_OFF
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> !rsp_valid)
      else $error("request accepted while a response is pending");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STATUS_OK) |-> rsp_data.read_value == '0)
      else $error("failed request returned a nonzero byte");

   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid)
      else $error("response repeated after being taken");
`endif

endmodule

### hdl/ibl_cell.sv
// ----------------------------------------------------------------------------
// ibl_cell
// One list position: holds a byte, loads it on append or write, and takes the
// right neighbor's byte on removal at or before its position if that neighbor is in the list.
// ----------------------------------------------------------------------------
module ibl_cell #(
   parameter int unsigned POS   = 0,
   parameter int unsigned CMP_W = 7
) (
   input  logic                     clock,
   input  ibl_pkg::cmd_type         cmd,
   input  logic [CMP_W-1:0]         index,
   input  logic [CMP_W-1:0]         count,
   input  logic [ibl_pkg::BYTE_W-1:0] neighbor,
   output logic [ibl_pkg::BYTE_W-1:0] data,
   output logic [ibl_pkg::BYTE_W-1:0] tap
);
   import ibl_pkg::*;

   localparam logic [CMP_W-1:0] MY_POS   = CMP_W'(POS);
   localparam logic [CMP_W-1:0] NEXT_POS = CMP_W'(POS + 1);

   logic [BYTE_W-1:0] data_ff;
   logic [BYTE_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (cmd.go && cmd.ok) begin
         case (cmd.kind)
            KIND_APPEND: begin
               if (count == MY_POS) data_in = cmd.value;
            end
            KIND_REMOVE: begin
               // close the gap left at index
               if ((MY_POS >= index) && (NEXT_POS < count)) data_in = neighbor;
            end
            KIND_WRITE: begin
               if (index == MY_POS) data_in = cmd.value;
            end
            default: begin
               data_in = data_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
   assign tap  = (index == MY_POS) ? data_ff : '0;

endmodule

### hdl/ibl_or_tree.sv
// ----------------------------------------------------------------------------
// ibl_or_tree
// Registered OR reduction of the cell read taps; at most one tap is nonzero,
// so the root carries the selected byte once a load has passed the leaf register and every OR level.
// ----------------------------------------------------------------------------
module ibl_or_tree #(
   parameter int unsigned LEAVES = ibl_pkg::DEFAULT_CAPACITY
) (
   input  logic                                  clock,
   input  logic                                  load,
   input  logic [LEAVES-1:0][ibl_pkg::BYTE_W-1:0] taps,
   output logic [ibl_pkg::BYTE_W-1:0]            root
);
   import ibl_pkg::*;

   localparam int unsigned LEVELS = tree_levels(LEAVES);
   localparam int unsigned PAD    = 1 << (TREE_FAN_BITS * LEVELS);

   logic [LEVELS:0][PAD-1:0][BYTE_W-1:0] node_ff;
   logic [LEVELS:1][PAD-1:0][BYTE_W-1:0] node_in;
   logic [PAD-1:0][BYTE_W-1:0]           leaf_in;

   always_comb begin
      leaf_in = '0;
      for (int j = 0; j < LEAVES; j++) begin
         leaf_in[j] = taps[j];
      end
   end

   always_comb begin
      node_in = '0;
      for (int k = 1; k <= LEVELS; k++) begin
         for (int j = 0; j < PAD / TREE_FAN; j++) begin
            if (j < (PAD >> (TREE_FAN_BITS * k))) begin
               for (int m = 0; m < TREE_FAN; m++) begin
                  node_in[k][j] = node_in[k][j] | node_ff[k-1][(j << TREE_FAN_BITS) + m];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         node_ff[0] <= leaf_in;
      end
      for (int k = 1; k <= LEVELS; k++) begin
         node_ff[k] <= node_in[k];
      end
   end

   assign root = node_ff[LEVELS][0];

endmodule
